@@ rtl/pss_pkg.sv @@
// Shared constants, opcodes, status codes and interface types of the subscription table
package pss_pkg;

	localparam int CLIENTS_DEF = 32;
	localparam int TOPICS_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;

	localparam logic [2:0] OP_CONNECT    = 3'd0;
	localparam logic [2:0] OP_DISCONNECT = 3'd1;
	localparam logic [2:0] OP_SUBSCRIBE  = 3'd2;
	localparam logic [2:0] OP_UNSUB      = 3'd3;
	localparam logic [2:0] OP_PUBLISH    = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_LIMIT   = 3'd2;
	localparam logic [2:0] ST_DUP     = 3'd3;
	localparam logic [2:0] ST_NOTSUB  = 3'd4;
	localparam logic [2:0] ST_BADSLOT = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [4:0]  client;
		logic [31:0] topic;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  slot;
		logic [4:0]  moved_from;
		logic [31:0] subscriber_mask;
	} rsp_t;

	typedef struct packed {
		logic       latch;
		logic       idx_clr;
		logic       scan_rd;
		logic       sel_last;
		logic       connect;
		logic       disc_fin;
		logic       sub_wr;
		logic       tail_rd;
		logic       unsub_wr;
		logic       report;
		logic [2:0] rstat;
		logic       give_slot;
		logic       give_moved;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       slot_ok;
		logic       full;
		logic       last_is_c;
		logic       found;
		logic       cnt_full;
		logic       scan_last;
	} sts_t;

endpackage

@@ rtl/pubsub_subscription_table_core.sv @@
// Top level of the publish/subscribe subscription table
//
//  port     dir  kind     meaning
//  start    in   strobe   command offered; taken when busy is low
//  busy     out  level    command in progress
//  req      in   struct   op, client, topic
//  done     out  strobe   result present for this cycle only
//  rsp      out  struct   status, slot, moved_from, subscriber_mask
//
// Connect, unknown ops, bad-slot refusals and a disconnect of the last slot finish
// straight from the execute step; subscribe, publish and any other disconnect scan
// the whole list, drain and finish; unsubscribe adds a tail read and a write when
// the key is found. The scan reads one list entry per cycle from every slot's RAM
// at once. Reset clears slot count and list lengths; no clearing pass. The result is
// registered, shown in the cycle after the final step; the receiver cannot stall.
module pubsub_subscription_table_core #(
	parameter int CLIENTS           = pss_pkg::CLIENTS_DEF,
	parameter int TOPICS_PER_CLIENT = pss_pkg::TOPICS_DEF,
	parameter int KEY_BITS          = pss_pkg::KEY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pss_pkg::req_t req,
	output logic          done,
	output pss_pkg::rsp_t rsp
);

	pss_pkg::cmd_t cmd;
	pss_pkg::sts_t sts;

	pss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pss_dp #(
		.CLIENTS           (CLIENTS),
		.TOPICS_PER_CLIENT (TOPICS_PER_CLIENT),
		.KEY_BITS          (KEY_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

@@ rtl/pss_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module pss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/pss_ctrl.sv @@
// Command sequencer of the subscription table
module pss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pss_pkg::sts_t sts,
	output pss_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_TAIL  = 3'd5;
	localparam logic [2:0] S_UWR   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.idx_clr = 1'b1;
				unique case (sts.op)
					pss_pkg::OP_CONNECT: begin
						cmd.report    = 1'b1;
						cmd.rstat     = sts.full ? pss_pkg::ST_FULL : pss_pkg::ST_OK;
						cmd.give_slot = !sts.full;
						cmd.connect   = !sts.full;
						state_d       = S_IDLE;
					end
					pss_pkg::OP_DISCONNECT: begin
						if (!sts.slot_ok) begin
							cmd.report = 1'b1;
							cmd.rstat  = pss_pkg::ST_BADSLOT;
							state_d    = S_IDLE;
						end else if (sts.last_is_c) begin
							// last slot freed: nothing moves
							cmd.sel_last   = 1'b1;
							cmd.disc_fin   = 1'b1;
							cmd.report     = 1'b1;
							cmd.rstat      = pss_pkg::ST_OK;
							cmd.give_moved = 1'b1;
							state_d        = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					pss_pkg::OP_SUBSCRIBE, pss_pkg::OP_UNSUB: begin
						if (!sts.slot_ok) begin
							cmd.report = 1'b1;
							cmd.rstat  = pss_pkg::ST_BADSLOT;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					pss_pkg::OP_PUBLISH: state_d = S_SCAN;
					default: begin
						cmd.report = 1'b1;
						cmd.rstat  = pss_pkg::ST_OK;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_FIN;
			S_FIN: begin
				state_d = S_IDLE;
				unique case (sts.op)
					pss_pkg::OP_DISCONNECT: begin
						cmd.sel_last   = 1'b1;
						cmd.disc_fin   = 1'b1;
						cmd.report     = 1'b1;
						cmd.rstat      = pss_pkg::ST_OK;
						cmd.give_moved = 1'b1;
					end
					pss_pkg::OP_SUBSCRIBE: begin
						cmd.report = 1'b1;
						priority if (sts.found) begin
							cmd.rstat = pss_pkg::ST_DUP;
						end else if (sts.cnt_full) begin
							cmd.rstat = pss_pkg::ST_LIMIT;
						end else begin
							cmd.rstat  = pss_pkg::ST_OK;
							cmd.sub_wr = 1'b1;
						end
					end
					pss_pkg::OP_UNSUB: begin
						if (!sts.found) begin
							cmd.report = 1'b1;
							cmd.rstat  = pss_pkg::ST_NOTSUB;
						end else begin
							state_d = S_TAIL;
						end
					end
					default: begin
						cmd.report = 1'b1;
						cmd.rstat  = pss_pkg::ST_OK;
					end
				endcase
			end
			S_TAIL: begin
				cmd.tail_rd = 1'b1;
				state_d     = S_UWR;
			end
			S_UWR: begin
				// move the tail key into the removed key's place
				cmd.unsub_wr = 1'b1;
				cmd.report   = 1'b1;
				cmd.rstat    = pss_pkg::ST_OK;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/pss_dp.sv @@
// Datapath: per-slot key RAMs, list lengths, slot count, scan compare and result register
module pss_dp #(
	parameter int CLIENTS           = pss_pkg::CLIENTS_DEF,
	parameter int TOPICS_PER_CLIENT = pss_pkg::TOPICS_DEF,
	parameter int KEY_BITS          = pss_pkg::KEY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pss_pkg::req_t req,
	input  pss_pkg::cmd_t cmd,
	output pss_pkg::sts_t sts,
	output logic          done,
	output pss_pkg::rsp_t rsp
);

	localparam int CW  = $clog2(CLIENTS + 1);
	localparam int CIW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int NW  = $clog2(TOPICS_PER_CLIENT + 1);
	localparam int IW  = (TOPICS_PER_CLIENT > 1) ? $clog2(TOPICS_PER_CLIENT) : 1;
	localparam int MW  = (CLIENTS < 32) ? CLIENTS : 32;

	logic [2:0]          op_q;
	logic [4:0]          client_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       cc_q;
	logic [NW-1:0]       cnt_q [CLIENTS];
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       cidx_s1;
	logic                chk_s1;
	logic                found_q;
	logic [IW-1:0]       at_q;
	logic [31:0]         mask_q;
	pss_pkg::rsp_t       rsp_q;
	logic                done_q;

	logic [KEY_BITS-1:0] rdata [CLIENTS];
	logic [CW-1:0]       last;
	logic [CIW-1:0]      c_idx;
	logic [CIW-1:0]      last_idx;
	logic [NW-1:0]       cnt_sel;
	logic [IW-1:0]       raddr;
	logic [IW-1:0]       waddr;
	logic [KEY_BITS-1:0] wdata;
	logic                wr;
	logic                lane_hit;
	logic [31:0]         hits;

	assign last     = cc_q - CW'(1);
	assign c_idx    = CIW'(client_q);
	assign last_idx = CIW'(last);
	assign cnt_sel  = cnt_q[cmd.sel_last ? last_idx : c_idx];
	assign raddr    = cmd.tail_rd ? IW'(cnt_sel - NW'(1)) : idx_q;

	assign sts.op        = op_q;
	assign sts.slot_ok   = (CW + 5)'(client_q) < (CW + 5)'(cc_q);
	assign sts.full      = (cc_q == CW'(CLIENTS));
	assign sts.last_is_c = ((CW + 5)'(client_q) == (CW + 5)'(last));
	assign sts.found     = found_q;
	assign sts.cnt_full  = (cnt_sel == NW'(TOPICS_PER_CLIENT));
	assign sts.scan_last = (idx_q == IW'(TOPICS_PER_CLIENT - 1));

	// all writes land in the addressed client's list
	always_comb begin
		wr    = 1'b0;
		waddr = cidx_s1;
		wdata = rdata[last_idx];
		priority if (chk_s1 && op_q == pss_pkg::OP_DISCONNECT) begin
			wr = 1'b1;
		end else if (cmd.sub_wr) begin
			wr    = 1'b1;
			waddr = IW'(cnt_sel);
			wdata = key_q;
		end else if (cmd.unsub_wr) begin
			wr    = 1'b1;
			waddr = at_q;
			wdata = rdata[c_idx];
		end else begin
			wr = 1'b0;
		end
	end

	for (genvar g = 0; g < CLIENTS; g++) begin : g_lane
		pss_ram #(.WIDTH(KEY_BITS), .DEPTH(TOPICS_PER_CLIENT)) u_ram (
			.clk   (clk),
			.we    (wr && (c_idx == CIW'(g))),
			.waddr (waddr),
			.wdata (wdata),
			.raddr (raddr),
			.rdata (rdata[g])
		);
	end

	assign lane_hit = (NW'(cidx_s1) < cnt_q[c_idx]) && (rdata[c_idx] == key_q);

	always_comb begin
		hits = '0;
		for (int j = 0; j < MW; j++) begin
			hits[j] = (CW'(j) < cc_q) && (NW'(cidx_s1) < cnt_q[j]) && (rdata[j] == key_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= req.op;
			client_q <= req.client;
			key_q    <= KEY_BITS'(req.topic);
		end
		cidx_s1 <= idx_q;
		if (cmd.idx_clr) begin
			found_q <= 1'b0;
			mask_q  <= '0;
		end else if (chk_s1) begin
			if (op_q == pss_pkg::OP_PUBLISH) begin
				mask_q <= mask_q | hits;
			end else if (lane_hit) begin
				found_q <= 1'b1;
				at_q    <= cidx_s1;
			end
		end
		if (cmd.report) begin
			rsp_q.status          <= cmd.rstat;
			rsp_q.slot            <= cmd.give_slot ? 5'(cc_q) : 5'd0;
			rsp_q.moved_from      <= cmd.give_moved ? 5'(last) : 5'd0;
			rsp_q.subscriber_mask <= (op_q == pss_pkg::OP_PUBLISH) ? mask_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			idx_q  <= '0;
			chk_s1 <= 1'b0;
			done_q <= 1'b0;
			for (int j = 0; j < CLIENTS; j++) begin
				cnt_q[j] <= '0;
			end
		end else begin
			done_q <= cmd.report;
			chk_s1 <= cmd.scan_rd;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_rd) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.connect) begin
				cnt_q[CIW'(cc_q)] <= '0;
				cc_q              <= cc_q + CW'(1);
			end
			if (cmd.disc_fin) begin
				cnt_q[c_idx] <= cnt_sel;
				cc_q         <= last;
			end
			if (cmd.sub_wr) begin
				cnt_q[c_idx] <= cnt_sel + NW'(1);
			end
			if (cmd.unsub_wr) begin
				cnt_q[c_idx] <= cnt_sel - NW'(1);
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ test/pubsub_subscription_table_core_test.sv @@
// Self-checking testbench of the subscription table core: random command streams against a predictor
module pubsub_subscription_table_core_test;
	import pss_pkg::*;

	localparam int NCLI = 32;
	localparam int NTOP = 16;

	// Predictor of the table plus queue of expected responses
	class sub_table_scoreboard;
		logic [31:0] keys [NCLI][NTOP];
		int unsigned list_len [NCLI];
		int unsigned n_clients;
		rsp_t pending [$];
		int errors;

		function new();
			n_clients = 0;
			errors = 0;
			foreach (list_len[i]) list_len[i] = 0;
		endfunction

		function int find_key(int unsigned s, logic [31:0] k);
			for (int i = 0; i < list_len[s]; i++)
				if (keys[s][i] == k) return i;
			return -1;
		endfunction

		function void note_command(req_t r);
			rsp_t e;
			int at;
			int unsigned last;
			bit ok;
			e = '0;
			ok = r.client < n_clients;
			case (r.op)
				OP_CONNECT: begin
					if (n_clients < NCLI) begin
						e.slot = n_clients[4:0];
						list_len[n_clients] = 0;
						n_clients++;
					end else e.status = ST_FULL;
				end
				OP_DISCONNECT: begin
					if (!ok) e.status = ST_BADSLOT;
					else begin
						last = n_clients - 1;
						if (last != r.client) begin
							keys[r.client] = keys[last];
							list_len[r.client] = list_len[last];
						end
						e.moved_from = last[4:0];
						n_clients--;
					end
				end
				OP_SUBSCRIBE: begin
					if (!ok) e.status = ST_BADSLOT;
					else if (find_key(r.client, r.topic) >= 0) e.status = ST_DUP;
					else if (list_len[r.client] >= NTOP) e.status = ST_LIMIT;
					else begin
						keys[r.client][list_len[r.client]] = r.topic;
						list_len[r.client]++;
					end
				end
				OP_UNSUB: begin
					if (!ok) e.status = ST_BADSLOT;
					else begin
						at = find_key(r.client, r.topic);
						if (at < 0) e.status = ST_NOTSUB;
						else begin
							keys[r.client][at] = keys[r.client][list_len[r.client] - 1];
							list_len[r.client]--;
						end
					end
				end
				OP_PUBLISH: begin
					for (int j = 0; j < n_clients; j++)
						if (find_key(j, r.topic) >= 0) e.subscriber_mask[j] = 1'b1;
				end
				default: ;
			endcase
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, a.status);
				errors++;
			end
			if (a.slot !== e.slot) begin
				$error("slot expected %0d actual %0d", e.slot, a.slot);
				errors++;
			end
			if (a.moved_from !== e.moved_from) begin
				$error("moved_from expected %0d actual %0d", e.moved_from, a.moved_from);
				errors++;
			end
			if (a.subscriber_mask !== e.subscriber_mask) begin
				$error("subscriber_mask expected %h actual %h",
					e.subscriber_mask, a.subscriber_mask);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t rsp;
	int idle_pct = 0;
	logic [31:0] hot_keys [8];
	sub_table_scoreboard sb;

	pubsub_subscription_table_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_response(rsp);
		if (arst_n && start && !busy) sb.note_command(req);
	end

	// Offer one transaction and hold it until taken; start stays high for the next one
	task automatic issue(input logic [2:0] op, input logic [4:0] cl, input logic [31:0] tp);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{op: op, client: cl, topic: tp};
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_command();
		int unsigned r;
		logic [4:0] cl;
		logic [31:0] tp;
		r = $urandom_range(99);
		cl = (sb.n_clients > 0 && $urandom_range(9) != 0) ?
			5'($urandom_range(sb.n_clients - 1)) : 5'($urandom);
		tp = ($urandom_range(9) < 8) ? hot_keys[$urandom_range(7)] : $urandom;
		if (r < 12) issue(OP_CONNECT, 5'($urandom), $urandom);
		else if (r < 20) issue(OP_DISCONNECT, cl, $urandom);
		else if (r < 55) issue(OP_SUBSCRIBE, cl, tp);
		else if (r < 72) issue(OP_UNSUB, cl, tp);
		else if (r < 97) issue(OP_PUBLISH, cl, tp);
		else issue(3'($urandom_range(7, 5)), 5'($urandom), $urandom);
	endtask

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		sb = new();
		foreach (hot_keys[i]) hot_keys[i] = $urandom;
		hot_keys[0] = 32'h0;
		hot_keys[1] = 32'hFFFF_FFFF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: empty table, bad slots, unknown ops, fill, duplicate, full list
		issue(OP_DISCONNECT, 5'd0, 32'h0);
		issue(OP_SUBSCRIBE, 5'd31, 32'hFFFF_FFFF);
		issue(OP_PUBLISH, 5'd0, 32'h0);
		issue(3'd5, 5'd31, 32'hFFFF_FFFF);
		issue(3'd7, 5'd0, 32'h0);
		issue(OP_CONNECT, 5'd0, 32'h0);
		issue(OP_SUBSCRIBE, 5'd0, 32'h0);
		issue(OP_SUBSCRIBE, 5'd0, 32'h0);
		issue(OP_UNSUB, 5'd0, 32'h1234);
		for (int i = 1; i < 16; i++) issue(OP_SUBSCRIBE, 5'd0, 32'(i));
		issue(OP_SUBSCRIBE, 5'd0, 32'hFFFF_FFFF);
		issue(OP_SUBSCRIBE, 5'd0, 32'd3);
		issue(OP_UNSUB, 5'd0, 32'd0);
		issue(OP_PUBLISH, 5'd0, 32'd15);
		issue(OP_DISCONNECT, 5'd0, 32'h0);
		drain();
		// Random phases with varying sender idling; fill table past full in one
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 53;
				2: idle_pct = 0;
				default: idle_pct = 7;
			endcase
			if (ph == 4) repeat (34) issue(OP_CONNECT, 5'($urandom), $urandom);
			for (int n = 0; n < 200; n++) random_command();
			drain();
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
